// ===== rtl/was_pkg.sv =====
// Shared types, constants and time helpers for the weekly alarm scheduler.
package was_pkg;

   localparam int unsigned MINS_PER_HOUR = 60;
   localparam int unsigned MINS_PER_DAY  = 1440;
   localparam int unsigned DAYS_PER_WEEK = 7;
   localparam int unsigned MOD_W         = 11;
   localparam int unsigned MINS_W        = 14;
   localparam int unsigned SUM_W         = 15;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_TIME  = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [3:0] slot;
      logic       enable;
      logic [4:0] alarm_hour;
      logic [5:0] alarm_minute;
      logic [7:0] weekday_mask;
      logic [2:0] now_weekday;
      logic [4:0] now_hour;
      logic [5:0] now_minute;
   } req_type;

   typedef struct packed {
      logic              ring;
      logic              found;
      logic [3:0]        next_slot;
      logic [MINS_W-1:0] minutes_until;
   } rsp_type;

   typedef struct packed {
      logic       enable;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [7:0] mask;
   } entry_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic              hit;
      logic              ring;
      logic [MINS_W-1:0] mins;
   } eval_type;

   function automatic logic [MOD_W-1:0] minute_of_day(input logic [4:0] hour,
                                                      input logic [5:0] minute);
      logic [4:0] h;
      logic [5:0] m;
      h = (hour > 5'd23) ? 5'd23 : hour;
      m = (minute > 6'd59) ? 6'd59 : minute;
      return MOD_W'(h) * MOD_W'(MINS_PER_HOUR) + MOD_W'(m);
   endfunction

   function automatic logic [2:0] fold_weekday(input logic [2:0] wd);
      return (wd == 3'd7) ? 3'd0 : wd;
   endfunction

   function automatic logic [MINS_W-1:0] day_base(input logic [2:0] k);
      logic [MINS_W-1:0] r;
      case (k)
         3'd1:    r = MINS_W'(1 * MINS_PER_DAY);
         3'd2:    r = MINS_W'(2 * MINS_PER_DAY);
         3'd3:    r = MINS_W'(3 * MINS_PER_DAY);
         3'd4:    r = MINS_W'(4 * MINS_PER_DAY);
         3'd5:    r = MINS_W'(5 * MINS_PER_DAY);
         3'd6:    r = MINS_W'(6 * MINS_PER_DAY);
         3'd7:    r = MINS_W'(7 * MINS_PER_DAY);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/was_table.sv =====
// Alarm table memory with per-entry valid bits and a registered read.
module was_table #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  was_pkg::entry_type    wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic                  rd_valid,
   output was_pkg::entry_type    rd_data
);

   was_pkg::entry_type mem [DEPTH];
   logic [DEPTH-1:0]   written_ff;
   was_pkg::entry_type rd_data_ff;
   logic               rd_written_ff;
   logic               rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
         rd_valid_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= rd_en;
         if (rd_en) begin
            rd_written_ff <= written_ff[rd_addr];
         end
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_data  = rd_written_ff ? rd_data_ff : '0;

endmodule

// ===== rtl/was_scan.sv =====
// Per-entry evaluation: ring match and soonest weekday occurrence, registered.
module was_scan #(
   parameter int unsigned AW = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic                           in_last,
   input  logic [AW-1:0]                  in_slot,
   input  was_pkg::entry_type             entry,
   input  logic [was_pkg::MOD_W-1:0]      now_min,
   input  logic [2:0]                     now_wd,
   output was_pkg::eval_type              eval,
   output logic [AW-1:0]                  eval_slot
);

   was_pkg::eval_type             eval_ff;
   was_pkg::eval_type             eval_in;
   logic [AW-1:0]                 slot_ff;
   logic [was_pkg::MOD_W-1:0]     amin;
   logic [6:0]                    active;
   logic                          today;
   logic                          any_day;
   logic [2:0]                    k_sel;
   logic [3:0]                    day_sum;
   logic [2:0]                    day_idx;
   logic [was_pkg::SUM_W-1:0]     later;

   always_comb begin
      amin = was_pkg::minute_of_day(entry.hour, entry.minute);
      for (int d = 0; d < 7; d++) begin
         active[d] = entry.mask[7-d];
      end
      today   = active[now_wd];
      any_day = |active;
      k_sel   = 3'd7;
      for (int k = 6; k >= 1; k--) begin
         day_sum = 4'(now_wd) + 4'(k);
         day_idx = (day_sum >= 4'd7) ? 3'(day_sum - 4'd7) : 3'(day_sum);
         if (active[day_idx]) begin
            k_sel = 3'(k);
         end
      end
      later = was_pkg::SUM_W'(was_pkg::day_base(k_sel)) - was_pkg::SUM_W'(now_min)
              + was_pkg::SUM_W'(amin);

      eval_in.valid = in_valid;
      eval_in.last  = in_last;
      eval_in.hit   = entry.enable && any_day;
      eval_in.ring  = entry.enable && today && (amin == now_min);
      if (today && (amin >= now_min)) begin
         eval_in.mins = was_pkg::MINS_W'(amin - now_min);
      end else begin
         eval_in.mins = was_pkg::MINS_W'(later);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eval_ff <= '0;
      end else begin
         eval_ff <= eval_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= in_slot;
   end

   assign eval      = eval_ff;
   assign eval_slot = slot_ff;

endmodule

// ===== rtl/weekly_alarm_scheduler.sv =====
// Top level: weekly alarm table with a one-slot-per-cycle next-alarm scan.
//
// channel   ports                    handshake
// request   start, busy, req_data    taken when start high and busy low
// response  rsp_valid, rsp_data      one-cycle strobe, no backpressure
//
// A write item leaves busy low.
// A time item holds busy while it issues one table read per slot through the
// single memory read port, then while the read and evaluate registers drain.
// The result strobes in the cycle busy drops; the next item may start then.
// Reset clears the table through per-slot valid bits.
module weekly_alarm_scheduler #(
   parameter int unsigned NUM_ALARMS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  was_pkg::req_type  req_data,
   output logic              rsp_valid,
   output was_pkg::rsp_type  rsp_data
);

   localparam int unsigned AW = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_ALARMS - 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ISSUE = 3'b010,
      ST_WAIT  = 3'b100
   } state_type;

   state_type                   state_ff, state_in;
   logic [AW-1:0]               cnt_ff, cnt_in;
   logic [was_pkg::MOD_W-1:0]   now_min_ff;
   logic [2:0]                  now_wd_ff;
   logic                        issue_last_ff;
   logic [AW-1:0]               issue_slot_ff;
   logic                        ring_ff, ring_in;
   logic                        found_ff, found_in;
   logic [AW-1:0]               best_slot_ff, best_slot_in;
   logic [was_pkg::MINS_W-1:0]  best_mins_ff, best_mins_in;
   logic                        rsp_valid_ff;
   was_pkg::rsp_type            rsp_ff;

   logic                        accept;
   logic                        do_write;
   logic                        do_time;
   logic                        rd_en;
   logic                        rd_valid;
   was_pkg::entry_type          rd_data;
   was_pkg::entry_type          wr_data;
   was_pkg::eval_type           eval;
   logic [AW-1:0]               eval_slot;
   logic                        take;

   assign accept   = start && !busy;
   assign do_write = accept && (req_data.cmd == was_pkg::CMD_WRITE)
                     && (32'(req_data.slot) < NUM_ALARMS);
   assign do_time  = accept && (req_data.cmd == was_pkg::CMD_TIME);
   assign rd_en    = (state_ff == ST_ISSUE);

   assign wr_data.enable = req_data.enable;
   assign wr_data.hour   = req_data.alarm_hour;
   assign wr_data.minute = req_data.alarm_minute;
   assign wr_data.mask   = req_data.weekday_mask;

   was_table #(
      .DEPTH (NUM_ALARMS),
      .AW    (AW)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (do_write),
      .wr_addr  (AW'(req_data.slot)),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (cnt_ff),
      .rd_valid (rd_valid),
      .rd_data  (rd_data)
   );

   was_scan #(
      .AW (AW)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid),
      .in_last   (issue_last_ff),
      .in_slot   (issue_slot_ff),
      .entry     (rd_data),
      .now_min   (now_min_ff),
      .now_wd    (now_wd_ff),
      .eval      (eval),
      .eval_slot (eval_slot)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (do_time) begin
               state_in = ST_ISSUE;
               cnt_in   = '0;
            end
         end
         ST_ISSUE: begin
            if (cnt_ff == LAST_SLOT) begin
               state_in = ST_WAIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_WAIT: begin
            if (eval.valid && eval.last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      take         = eval.valid && eval.hit && (!found_ff || (eval.mins < best_mins_ff));
      ring_in      = ring_ff || (eval.valid && eval.ring);
      found_in     = found_ff || (eval.valid && eval.hit);
      best_slot_in = take ? eval_slot : best_slot_ff;
      best_mins_in = take ? eval.mins : best_mins_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ring_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= eval.valid && eval.last;
         if (do_time) begin
            ring_ff  <= 1'b0;
            found_ff <= 1'b0;
         end else begin
            ring_ff  <= ring_in;
            found_ff <= found_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_time) begin
         now_min_ff   <= was_pkg::minute_of_day(req_data.now_hour, req_data.now_minute);
         now_wd_ff    <= was_pkg::fold_weekday(req_data.now_weekday);
         best_slot_ff <= '0;
         best_mins_ff <= '0;
      end else begin
         best_slot_ff <= best_slot_in;
         best_mins_ff <= best_mins_in;
      end
      issue_last_ff <= (cnt_ff == LAST_SLOT);
      issue_slot_ff <= cnt_ff;
      if (eval.valid && eval.last) begin
         rsp_ff.ring          <= ring_in;
         rsp_ff.found         <= found_in;
         rsp_ff.next_slot     <= found_in ? 4'(best_slot_in) : 4'd0;
         rsp_ff.minutes_until <= found_in ? best_mins_in : '0;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/was_checker.sv =====
// Port-level checker for the weekly alarm scheduler, bound to the top level.
module was_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input was_pkg::req_type  req_data,
   input logic              rsp_valid,
   input was_pkg::rsp_type  rsp_data
);

   a_time_sets_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.cmd == was_pkg::CMD_TIME) |=> busy)
      else $error("time item did not raise busy");

   a_rsp_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         (rsp_data.next_slot == 4'd0) && (rsp_data.minutes_until == '0))
      else $error("empty result carries nonzero fields");

   a_ring_now: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ring |-> rsp_data.found && (rsp_data.minutes_until == '0))
      else $error("ring without a zero-distance alarm");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.minutes_until < 14'd10080))
      else $error("minutes_until beyond one week");

endmodule

bind weekly_alarm_scheduler was_checker u_was_checker (.*);

// ===== verif/weekly_alarm_scheduler_tb.sv =====
// Self-checking testbench for the weekly alarm scheduler: directed rows, then random items.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned NUM_ALARMS    = 16;
   localparam int unsigned RANDOM_ITEMS  = 880;
   localparam int unsigned STALL_LIMIT   = 5000;
   localparam int unsigned CALM_FIRST    = 400;
   localparam int unsigned CALM_LAST     = 560;
   localparam int unsigned IDLE_PERCENT  = 14;

   typedef struct {
      was_pkg::req_type req;
      bit               typed;
      was_pkg::rsp_type want;
   } stim_row;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   was_pkg::req_type req_data;
   logic             rsp_valid;
   was_pkg::rsp_type rsp_data;

   was_pkg::entry_type alarms [NUM_ALARMS];
   stim_row            stim_rows [$];
   was_pkg::rsp_type   expected_rsps [$];
   int unsigned        errors;
   int unsigned        stall_cycles;

   weekly_alarm_scheduler #(
      .NUM_ALARMS(NUM_ALARMS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic int unsigned day_minute(logic [4:0] h, logic [5:0] m);
      return ((h > 5'd23) ? 23 : h) * was_pkg::MINS_PER_HOUR + ((m > 6'd59) ? 59 : m);
   endfunction

   function automatic was_pkg::rsp_type scan_alarms(was_pkg::req_type r);
      was_pkg::rsp_type res;
      int unsigned      wd;
      int unsigned      now_m;
      int unsigned      a_m;
      int unsigned      ahead;
      int unsigned      mins;
      res   = '0;
      wd    = (r.now_weekday > 3'd6) ? 0 : r.now_weekday;
      now_m = day_minute(r.now_hour, r.now_minute);
      for (int s = 0; s < NUM_ALARMS; s++) begin
         if (alarms[s].enable) begin
            a_m = day_minute(alarms[s].hour, alarms[s].minute);
            if (a_m == now_m && alarms[s].mask[3'(7 - wd)])
               res.ring = 1'b1;
            for (int d = 0; d < was_pkg::DAYS_PER_WEEK; d++) begin
               if (alarms[s].mask[3'(7 - d)]) begin
                  ahead = (d + was_pkg::DAYS_PER_WEEK - wd) % was_pkg::DAYS_PER_WEEK;
                  if (ahead == 0 && a_m >= now_m) begin
                     mins = a_m - now_m;
                  end else begin
                     if (ahead == 0)
                        ahead = was_pkg::DAYS_PER_WEEK;
                     mins = (ahead - 1) * was_pkg::MINS_PER_DAY + was_pkg::MINS_PER_DAY
                            - now_m + a_m;
                  end
                  if (!res.found || mins < res.minutes_until) begin
                     res.found         = 1'b1;
                     res.minutes_until = was_pkg::MINS_W'(mins);
                     res.next_slot     = 4'(s);
                  end
               end
            end
         end
      end
      return res;
   endfunction

   function automatic stim_row write_row(logic [3:0] slot, logic en, logic [4:0] h,
                                         logic [5:0] m, logic [7:0] mask);
      stim_row row;
      row.req              = '0;
      row.req.cmd          = was_pkg::CMD_WRITE;
      row.req.slot         = slot;
      row.req.enable       = en;
      row.req.alarm_hour   = h;
      row.req.alarm_minute = m;
      row.req.weekday_mask = mask;
      row.typed            = 1'b0;
      row.want             = '0;
      return row;
   endfunction

   function automatic stim_row time_row(logic [2:0] wd, logic [4:0] h, logic [5:0] m,
                                        bit typed = 1'b0, was_pkg::rsp_type want = '0);
      stim_row row;
      row.req             = '0;
      row.req.cmd         = was_pkg::CMD_TIME;
      row.req.now_weekday = wd;
      row.req.now_hour    = h;
      row.req.now_minute  = m;
      row.typed           = typed;
      row.want            = want;
      return row;
   endfunction

   task automatic take_item(stim_row row);
      if (row.req.cmd == was_pkg::CMD_WRITE)
         alarms[row.req.slot] = {row.req.enable, row.req.alarm_hour,
                                 row.req.alarm_minute, row.req.weekday_mask};
      else
         expected_rsps.push_back(row.typed ? row.want : scan_alarms(row.req));
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      was_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $error("result with nothing expected: %p", rsp_data);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            check_field("ring", want.ring, rsp_data.ring);
            check_field("found", want.found, rsp_data.found);
            check_field("next_slot", want.next_slot, rsp_data.next_slot);
            check_field("minutes_until", want.minutes_until, rsp_data.minutes_until);
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      stim_row     row;
      logic [63:0] noise;
      logic [4:0]  gen_hour [NUM_ALARMS];
      logic [5:0]  gen_minute [NUM_ALARMS];
      int unsigned k;
      int unsigned idx;

      reset        = 1'b1;
      start        = 1'b0;
      req_data     = '0;
      errors       = 0;
      stall_cycles = 0;
      foreach (alarms[s])
         alarms[s] = '0;
      foreach (gen_hour[s]) begin
         gen_hour[s]   = '0;
         gen_minute[s] = '0;
      end

      stim_rows.push_back(time_row(3'd0, 5'd0, 6'd0, 1'b1, '{1'b0, 1'b0, 4'd0, 14'd0}));
      stim_rows.push_back(write_row(4'd15, 1'b1, 5'd31, 6'd63, 8'h01));
      stim_rows.push_back(time_row(3'd7, 5'd23, 6'd59, 1'b1, '{1'b0, 1'b0, 4'd0, 14'd0}));
      stim_rows.push_back(write_row(4'd15, 1'b1, 5'd31, 6'd63, 8'hFF));
      stim_rows.push_back(time_row(3'd7, 5'd31, 6'd63, 1'b1, '{1'b1, 1'b1, 4'd15, 14'd0}));
      stim_rows.push_back(write_row(4'd0, 1'b0, 5'd12, 6'd30, 8'hFE));
      stim_rows.push_back(time_row(3'd3, 5'd12, 6'd30, 1'b1, '{1'b0, 1'b1, 4'd15, 14'd689}));
      stim_rows.push_back(write_row(4'd3, 1'b1, 5'd12, 6'd30, 8'h20));
      stim_rows.push_back(time_row(3'd2, 5'd12, 6'd30, 1'b1, '{1'b1, 1'b1, 4'd3, 14'd0}));
      stim_rows.push_back(time_row(3'd2, 5'd12, 6'd31));
      stim_rows.push_back(write_row(4'd15, 1'b0, 5'd0, 6'd0, 8'h00));
      stim_rows.push_back(time_row(3'd2, 5'd12, 6'd31, 1'b1, '{1'b0, 1'b1, 4'd3, 14'd10079}));
      stim_rows.push_back(write_row(4'd7, 1'b1, 5'd12, 6'd30, 8'h20));
      stim_rows.push_back(time_row(3'd1, 5'd12, 6'd30, 1'b1, '{1'b0, 1'b1, 4'd3, 14'd1440}));
      stim_rows.push_back(write_row(4'd1, 1'b1, 5'd0, 6'd0, 8'h80));
      stim_rows.push_back(time_row(3'd6, 5'd23, 6'd59, 1'b1, '{1'b0, 1'b1, 4'd1, 14'd1}));
      stim_rows.push_back(write_row(4'd2, 1'b1, 5'd0, 6'd0, 8'hFE));
      stim_rows.push_back(time_row(3'd0, 5'd0, 6'd0, 1'b1, '{1'b1, 1'b1, 4'd1, 14'd0}));
      stim_rows.push_back(time_row(3'd4, 5'd23, 6'd0));
      stim_rows.push_back(write_row(4'd8, 1'b1, 5'd0, 6'd0, 8'h00));
      stim_rows.push_back(time_row(3'd5, 5'd10, 6'd15));
      stim_rows.push_back(write_row(4'd9, 1'b1, 5'd24, 6'd60, 8'h7F));
      stim_rows.push_back(time_row(3'd6, 5'd31, 6'd63));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         noise     = {$urandom, $urandom};
         row.req   = noise[$bits(was_pkg::req_type)-1:0];
         row.typed = 1'b0;
         row.want  = '0;
         if ($urandom_range(99) < 45) begin
            row.req.cmd    = was_pkg::CMD_WRITE;
            row.req.enable = ($urandom_range(99) < 70);
            if ($urandom_range(9) != 0) begin
               row.req.alarm_hour   = 5'($urandom_range(23));
               row.req.alarm_minute = 6'($urandom_range(59));
            end
            gen_hour[row.req.slot]   = row.req.alarm_hour;
            gen_minute[row.req.slot] = row.req.alarm_minute;
         end else begin
            row.req.cmd = was_pkg::CMD_TIME;
            if ($urandom_range(9) != 0) begin
               row.req.now_weekday = 3'($urandom_range(6));
               row.req.now_hour    = 5'($urandom_range(23));
               row.req.now_minute  = 6'($urandom_range(59));
            end
            if ($urandom_range(3) == 0) begin
               k                  = $urandom_range(NUM_ALARMS - 1);
               row.req.now_hour   = gen_hour[4'(k)];
               row.req.now_minute = gen_minute[4'(k)];
            end
         end
         stim_rows.push_back(row);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      idx = 0;
      while (idx < stim_rows.size()) begin
         if ((idx < CALM_FIRST || idx > CALM_LAST) && $urandom_range(99) < IDLE_PERCENT) begin
            start <= 1'b0;
         end else begin
            start    <= 1'b1;
            req_data <= stim_rows[idx].req;
         end
         @(posedge clock);
         if (start && !busy) begin
            take_item(stim_rows[idx]);
            idx++;
         end
      end
      start <= 1'b0;

      while (expected_rsps.size() != 0)
         @(posedge clock);
      repeat (NUM_ALARMS + 8) @(posedge clock);

      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
